[src/hcbd_pkg.sv]
// Shared types, codes and character helpers for the chunked body decoder.
// No dependencies; imported by the top level.
package hcbd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_LEN  = 3'd1;
  localparam logic [2:0] ERR_NO_CRLF  = 3'd2;
  localparam logic [2:0] ERR_EOF_DATA = 3'd3;
  localparam logic [2:0] ERR_EOF_HDR  = 3'd4;
  localparam logic [2:0] ERR_BAD_END  = 3'd5;

  // Input operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam int unsigned HEX_BITS = 4;

  typedef enum logic [3:0] {
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS,
    PH_SKIP,
    PH_DATA,
    PH_CR,
    PH_LF,
    PH_TRAILER,
    PH_DONE,
    PH_ERROR
  } phase_e;

  // Trailer line tracking
  typedef enum logic [1:0] {
    TRL_START,
    TRL_CR,
    TRL_OTHER
  } trl_e;

  typedef struct packed {
    logic                ok;
    logic [HEX_BITS-1:0] val;
  } hex_t;

  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = HEX_BITS'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = HEX_BITS'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = HEX_BITS'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

[src/hcbd_in_if.sv]
// Input channel: wire bytes and end-of-stream marks, valid/ready handshake.
// Depends on nothing.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_in;

  modport source (output valid, output op, output byte_in, input ready);
  modport sink   (input valid, input op, input byte_in, output ready);
endinterface

[src/hcbd_out_if.sv]
// Output channel: decoded payload bytes, message end and error results.
// Depends on nothing.
interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload;
  logic       chunk_end;
  logic [2:0] error_code;

  modport source (output valid, output kind, output payload, output chunk_end,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input payload, input chunk_end,
                  input error_code, output ready);
endinterface

[src/http_chunked_body_decoder_top.sv]
// HTTP/1.1 chunked body decoder: strips chunk framing from a byte stream.
// Depends on hcbd_pkg, hcbd_in_if and hcbd_out_if.
//
// The decoder takes one transaction per cycle on in_i: a wire byte (op 0) or an
// end-of-stream mark (op 1). Each transaction is decoded in the cycle it is
// accepted and yields at most one result, which lands in the output register
// and is offered on out_o the next cycle. The block sustains one transaction
// per clock; in_i.ready drops only while the output register holds a result
// that the sink has not yet taken. Size lines are parsed as hex with optional
// leading blanks, sign and 0x prefix; extensions are skipped up to LF. Payload
// bytes come out with chunk_end set on the last byte of each chunk. After a
// zero-size chunk, trailer lines are skipped until an empty CR LF line, then
// a message-complete result is sent and every later input is dropped. Any
// framing fault produces an error result that repeats for every later input
// until reset. LEN_BITS sets the largest accepted chunk size (2^LEN_BITS-1).
module http_chunked_body_decoder_top
  import hcbd_pkg::*;
#(
  parameter int unsigned LEN_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  hcbd_in_if.sink           in_i,
  hcbd_out_if.source        out_o
);

  // Decoder state
  phase_e              phase_q, phase_d;
  logic [LEN_BITS-1:0] rem_q, rem_d;       // payload bytes left in chunk
  logic [LEN_BITS-1:0] acc_q, acc_d;       // size being parsed
  logic                neg_q, neg_d;       // minus sign seen
  logic                ovf_q, ovf_d;       // size overflowed
  logic                has_chars_q, has_chars_d;
  trl_e                trl_q, trl_d;
  logic [2:0]          err_q, err_d;       // sticky error code

  // Output register
  logic       out_valid_q;
  logic [1:0] out_kind_q;
  logic [7:0] out_payload_q;
  logic       out_end_q;
  logic [2:0] out_code_q;

  // Result of the current transaction
  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_payload;
  logic       res_end;
  logic [2:0] res_code;

  logic       accept;
  logic [7:0] c;
  hex_t       hx;
  logic       size_bad;
  logic       acc_zero;
  logic       acc_full;   // one more digit would exceed the size range
  logic [LEN_BITS-1:0] rem_dec;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.byte_in;
  assign hx         = hex_val(c);
  assign acc_zero   = (acc_q == '0);
  assign size_bad   = ovf_q || (neg_q && !acc_zero);
  assign acc_full   = |acc_q[LEN_BITS-1 -: HEX_BITS];
  assign rem_dec    = rem_q - LEN_BITS'(1);

  always_comb begin
    phase_d     = phase_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    has_chars_d = has_chars_q;
    trl_d       = trl_q;
    err_d       = err_q;
    res_valid   = 1'b0;
    res_kind    = KIND_PAYLOAD;
    res_payload = '0;
    res_end     = 1'b0;
    res_code    = ERR_NONE;

    if (accept) begin
      if (phase_q == PH_ERROR) begin
        // sticky error repeats
        res_valid = 1'b1;
        res_kind  = KIND_ERROR;
        res_code  = err_q;
      end else if (phase_q == PH_DONE) begin
        // message over, drop input
      end else if (in_i.op == OP_EOS) begin
        res_valid = 1'b1;
        res_kind  = KIND_ERROR;
        phase_d   = PH_ERROR;
        unique case (phase_q)
          PH_DATA:      res_code = ERR_EOF_DATA;
          PH_CR, PH_LF: res_code = ERR_NO_CRLF;
          PH_TRAILER:   res_code = ERR_BAD_END;
          default: begin
            // inside a size line: judge the partial line
            if (!has_chars_q)   res_code = ERR_EOF_HDR;
            else if (size_bad)  res_code = ERR_BAD_LEN;
            else if (acc_zero)  res_code = ERR_BAD_END;
            else                res_code = ERR_EOF_DATA;
          end
        endcase
        err_d = res_code;
      end else begin
        unique case (phase_q)
          PH_DATA: begin
            rem_d       = rem_dec;
            res_valid   = 1'b1;
            res_kind    = KIND_PAYLOAD;
            res_payload = c;
            res_end     = (rem_dec == '0);
            if (rem_dec == '0) phase_d = PH_CR;
          end
          PH_CR: begin
            if (c == CH_CR) begin
              phase_d = PH_LF;
            end else begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              res_code  = ERR_NO_CRLF;
              err_d     = ERR_NO_CRLF;
              phase_d   = PH_ERROR;
            end
          end
          PH_LF: begin
            if (c == CH_LF) begin
              // next size line
              phase_d     = PH_LEAD;
              acc_d       = '0;
              neg_d       = 1'b0;
              ovf_d       = 1'b0;
              has_chars_d = 1'b0;
            end else begin
              res_valid = 1'b1;
              res_kind  = KIND_ERROR;
              res_code  = ERR_NO_CRLF;
              err_d     = ERR_NO_CRLF;
              phase_d   = PH_ERROR;
            end
          end
          PH_TRAILER: begin
            if (c == CH_LF) begin
              if (trl_q == TRL_CR) begin
                phase_d   = PH_DONE;
                res_valid = 1'b1;
                res_kind  = KIND_DONE;
              end
              trl_d = TRL_START;
            end else if (c == CH_CR && trl_q == TRL_START) begin
              trl_d = TRL_CR;
            end else begin
              trl_d = TRL_OTHER;
            end
          end
          default: begin
            // size line phases
            if (c == CH_LF) begin
              if (size_bad) begin
                res_valid = 1'b1;
                res_kind  = KIND_ERROR;
                res_code  = ERR_BAD_LEN;
                err_d     = ERR_BAD_LEN;
                phase_d   = PH_ERROR;
              end else if (acc_zero) begin
                phase_d = PH_TRAILER;
                trl_d   = TRL_START;
              end else begin
                rem_d   = acc_q;
                phase_d = PH_DATA;
              end
            end else begin
              has_chars_d = 1'b1;
              unique case (phase_q)
                PH_LEAD, PH_SIGNED: begin
                  if (phase_q == PH_LEAD && is_blank(c)) begin
                    phase_d = PH_LEAD;
                  end else if (phase_q == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
                    if (c == CH_MINUS) neg_d = 1'b1;
                    phase_d = PH_SIGNED;
                  end else if (c == CH_ZERO) begin
                    phase_d = PH_ZERO;
                  end else if (hx.ok) begin
                    if (acc_full) ovf_d = 1'b1;
                    else acc_d = {acc_q[LEN_BITS-HEX_BITS-1:0], hx.val};
                    phase_d = PH_DIGITS;
                  end else begin
                    phase_d = PH_SKIP;
                  end
                end
                PH_ZERO: begin
                  if (c == CH_LO_X || c == CH_UP_X) begin
                    phase_d = PH_PREFIX;
                  end else if (hx.ok) begin
                    if (acc_full) ovf_d = 1'b1;
                    else acc_d = {acc_q[LEN_BITS-HEX_BITS-1:0], hx.val};
                    phase_d = PH_DIGITS;
                  end else begin
                    phase_d = PH_SKIP;
                  end
                end
                PH_PREFIX, PH_DIGITS: begin
                  if (hx.ok) begin
                    if (acc_full) ovf_d = 1'b1;
                    else acc_d = {acc_q[LEN_BITS-HEX_BITS-1:0], hx.val};
                    phase_d = PH_DIGITS;
                  end else begin
                    phase_d = PH_SKIP;
                  end
                end
                default: phase_d = PH_SKIP;
              endcase
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      rem_q       <= '0;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      has_chars_q <= 1'b0;
      trl_q       <= TRL_START;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      rem_q       <= rem_d;
      acc_q       <= acc_d;
      neg_q       <= neg_d;
      ovf_q       <= ovf_d;
      has_chars_q <= has_chars_d;
      trl_q       <= trl_d;
      err_q       <= err_d;
      if (in_i.ready) begin
        out_valid_q <= res_valid;
      end
    end
  end

  // Result payload; loads whenever the register is free or being drained
  always_ff @(posedge clk_i) begin
    if (in_i.ready) begin
      out_kind_q    <= res_kind;
      out_payload_q <= res_payload;
      out_end_q     <= res_end;
      out_code_q    <= res_code;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.payload    = out_payload_q;
  assign out_o.chunk_end  = out_end_q;
  assign out_o.error_code = out_code_q;

endmodule
